### sv/binary_max_heap_queue_defines.svh
// Assertion macros shared by the heap queue RTL files.
// The macros expect signals named clk and rst_n in the module that uses them.
`ifndef BINARY_MAX_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MAX_HEAP_QUEUE_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define BMHQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// A property that must hold in the cycle after the condition.
`define BMHQ_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

### sv/bmhq_pkg.sv
// Package of the binary max-heap queue: sizes, item types, codes and the
// command and status groups between controller and datapath. No dependencies.
`default_nettype none

package bmhq_pkg;

  localparam int CAPACITY    = 256;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic                   operation;
    logic [VALUE_WIDTH-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] popped_value;
    logic [VALUE_WIDTH-1:0] top_value;
    logic [CNT_W-1:0]       count;
    status_t                status;
  } out_item_t;

  typedef struct packed {
    logic accept_full;
    logic accept_empty;
    logic push_init;
    logic pop_init;
    logic load_last;
    logic rd_parent;
    logic rd_child;
    logic write_val;
    logic move_up;
    logic move_down;
  } cmd_t;

  typedef struct packed {
    logic in_pop;
    logic full;
    logic empty;
    logic last_one;
    logic at_root;
    logic up_go;
    logic dn_leaf;
    logic dn_go;
  } sts_t;

endpackage

`default_nettype wire

### sv/bmhq_ctrl.sv
// Controller of the heap queue: a one-hot state machine that steps the
// datapath through push and pop sifts. Depends on bmhq_pkg.
`default_nettype none

module bmhq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire bmhq_pkg::sts_t sts,
  output bmhq_pkg::cmd_t     cmd,
  output logic               busy,
  output logic               out_valid
);
  import bmhq_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_POP_LD = 7'b0000010,
    S_UP_RD  = 7'b0000100,
    S_UP_CMP = 7'b0001000,
    S_DN_RD  = 7'b0010000,
    S_DN_CMP = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (sts.in_pop) begin
            if (sts.empty) begin
              cmd.accept_empty = 1'b1;
              state_nxt        = S_RESP;
            end else begin
              cmd.pop_init = 1'b1;
              state_nxt    = sts.last_one ? S_RESP : S_POP_LD;
            end
          end else begin
            if (sts.full) begin
              cmd.accept_full = 1'b1;
              state_nxt       = S_RESP;
            end else begin
              cmd.push_init = 1'b1;
              state_nxt     = S_UP_RD;
            end
          end
        end
      end
      S_POP_LD: begin
        cmd.load_last = 1'b1;
        state_nxt     = S_DN_RD;
      end
      S_UP_RD: begin
        if (sts.at_root) begin
          cmd.write_val = 1'b1;
          state_nxt     = S_RESP;
        end else begin
          cmd.rd_parent = 1'b1;
          state_nxt     = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.up_go) begin
          cmd.move_up = 1'b1;
          state_nxt   = S_UP_RD;
        end else begin
          cmd.write_val = 1'b1;
          state_nxt     = S_RESP;
        end
      end
      S_DN_RD: begin
        if (sts.dn_leaf) begin
          cmd.write_val = 1'b1;
          state_nxt     = S_RESP;
        end else begin
          cmd.rd_child = 1'b1;
          state_nxt    = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (sts.dn_go) begin
          cmd.move_down = 1'b1;
          state_nxt     = S_DN_RD;
        end else begin
          cmd.write_val = 1'b1;
          state_nxt     = S_RESP;
        end
      end
      S_RESP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_RESP);

endmodule

`default_nettype wire

### sv/bmhq_dp.sv
// Datapath of the heap queue: the heap memory with two registered read ports,
// the moving value, the hole position, the entry count and the result fields.
// Depends on bmhq_pkg and binary_max_heap_queue_defines.svh.
`default_nettype none
`include "binary_max_heap_queue_defines.svh"

module bmhq_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bmhq_pkg::in_item_t in_item,
  input  wire bmhq_pkg::cmd_t     cmd,
  output bmhq_pkg::sts_t          sts,
  output bmhq_pkg::out_item_t     out_item
);
  import bmhq_pkg::*;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [VALUE_WIDTH-1:0] mem [CAPACITY];

  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;
  logic [IDX_W-1:0]       pos_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [VALUE_WIDTH-1:0] top_r;
  logic [VALUE_WIDTH-1:0] popped_r;
  status_t                status_r;
  logic [VALUE_WIDTH-1:0] rd_a_r;
  logic [VALUE_WIDTH-1:0] rd_b_r;

  logic [IDX_W-1:0]       parent;
  logic [IDX_W:0]         left;
  logic [IDX_W+1:0]       right;
  logic [CNT_W-1:0]       last;
  logic                   right_ok;
  logic                   take_right;
  logic [IDX_W-1:0]       pick_idx;
  logic [VALUE_WIDTH-1:0] pick_val;
  logic [IDX_W-1:0]       rd_a_addr;
  logic                   rd_en;
  logic                   wr_en;
  logic [VALUE_WIDTH-1:0] wr_data;

  assign parent     = (pos_r - IDX_W'(1)) >> 1;
  assign left       = {pos_r, 1'b1};
  assign right      = {1'b0, left} + (IDX_W+2)'(1);
  assign last       = count_r - CNT_W'(1);
  assign right_ok   = (right < (IDX_W+2)'(count_r));
  assign take_right = right_ok && (rd_b_r > rd_a_r);
  assign pick_idx   = take_right ? right[IDX_W-1:0] : left[IDX_W-1:0];
  assign pick_val   = take_right ? rd_b_r : rd_a_r;

  always_comb begin
    if (cmd.pop_init) begin
      rd_a_addr = last[IDX_W-1:0];
    end else if (cmd.rd_child) begin
      rd_a_addr = left[IDX_W-1:0];
    end else begin
      rd_a_addr = parent;
    end
  end

  assign rd_en = cmd.pop_init | cmd.rd_parent | cmd.rd_child;
  assign wr_en = cmd.write_val | cmd.move_up | cmd.move_down;

  always_comb begin
    if (cmd.move_up) begin
      wr_data = rd_a_r;
    end else if (cmd.move_down) begin
      wr_data = pick_val;
    end else begin
      wr_data = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= mem[rd_a_addr];
      rd_b_r <= mem[right[IDX_W-1:0]];
    end
    if (wr_en) begin
      mem[pos_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (pos_r == '0)) begin
      top_r <= wr_data;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.push_init) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop_init) begin
      count_nxt = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_full) begin
      popped_r <= '0;
      status_r <= ST_FULL;
    end else if (cmd.accept_empty) begin
      popped_r <= '0;
      status_r <= ST_EMPTY;
    end else if (cmd.push_init) begin
      popped_r <= '0;
      status_r <= ST_OK;
      val_r    <= in_item.value;
      pos_r    <= count_r[IDX_W-1:0];
    end else if (cmd.pop_init) begin
      popped_r <= top_r;
      status_r <= ST_OK;
    end else if (cmd.load_last) begin
      val_r <= rd_a_r;
      pos_r <= '0;
    end else if (cmd.move_up) begin
      pos_r <= parent;
    end else if (cmd.move_down) begin
      pos_r <= pick_idx;
    end
  end

  assign sts.in_pop   = (in_item.operation == OP_POP);
  assign sts.full     = (count_r == CAP_CNT);
  assign sts.empty    = (count_r == '0);
  assign sts.last_one = (count_r == CNT_W'(1));
  assign sts.at_root  = (pos_r == '0);
  assign sts.up_go    = (val_r > rd_a_r);
  assign sts.dn_leaf  = (left >= (IDX_W+1)'(count_r));
  assign sts.dn_go    = (val_r < pick_val);

  assign out_item.popped_value = popped_r;
  assign out_item.top_value    = (count_r != '0) ? top_r : '0;
  assign out_item.count        = count_r;
  assign out_item.status       = status_r;

  `BMHQ_ASSERT(a_count_in_range, count_r <= CAP_CNT, "Entry count exceeds capacity.")
  `BMHQ_ASSERT_NEXT(a_push_grows, cmd.push_init, count_r == $past(count_r) + CNT_W'(1),
                    "Push did not add one entry.")
  `BMHQ_ASSERT_NEXT(a_pop_shrinks, cmd.pop_init, count_r == $past(count_r) - CNT_W'(1),
                    "Pop did not remove one entry.")
  `BMHQ_ASSERT_NEXT(a_up_climbs, cmd.move_up, pos_r < $past(pos_r),
                    "Sift-up step did not move toward the root.")
  `BMHQ_ASSERT_NEXT(a_down_descends, cmd.move_down, pos_r > $past(pos_r),
                    "Sift-down step did not move toward the leaves.")

endmodule

`default_nettype wire

### sv/binary_max_heap_queue.sv
// Top level of the binary max-heap priority queue: joins controller and
// datapath. Depends on bmhq_pkg, bmhq_ctrl and bmhq_dp.
//
// An item is a push of in_item.value (operation 0) or a pop of the largest
// entry (operation 1). It is taken at a rising edge where start is high and
// busy is low. Each item gives exactly one result on out_item, shown for one
// cycle with out_valid high; the receiver must take it then.
// A result carries the popped value (zero unless a pop succeeded), the largest
// entry held afterward (zero when empty), the entry count and a status: ok,
// pop on an empty queue, or push on a full queue. Flagged items change nothing.
// Items are worked one at a time. A rejected item or a pop that empties the
// queue goes straight to the result. A push climbs from the new leaf, at most
// 8 levels, to the root or until its parent is not smaller. A pop takes the
// last entry and sinks it from the root, at most 7 levels, to a leaf or until
// no child is larger. Each level takes a memory read state and then a compare
// and write state. The next item can be taken in the cycle after out_valid.
// Reset empties the queue; the heap memory is not cleared.
`default_nettype none

module binary_max_heap_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire bmhq_pkg::in_item_t  in_item,
  output logic                     busy,
  output logic                     out_valid,
  output bmhq_pkg::out_item_t      out_item
);
  import bmhq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bmhq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  bmhq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule

`default_nettype wire
